@@ hdl/swpd_pkg.sv @@
// Shared types and constants for the sync-word packet deframer.
package swpd_pkg;

  localparam logic [31:0] SyncWordReset = 32'h7FF0_1CAF;
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned PayloadBytes  = 16;
  localparam logic [4:0]  PosHunt       = 5'd0;
  localparam logic [4:0]  PosLastHeader = 5'(HeaderBytes - 1);
  localparam logic [4:0]  PosFirstData  = 5'(HeaderBytes);
  localparam logic [4:0]  PosLastData   = 5'(HeaderBytes + PayloadBytes - 1);

  typedef struct packed {
    logic [31:0] frame_count;
    logic [31:0] x_rate_bits;
    logic [31:0] y_rate_bits;
    logic [31:0] z_rate_bits;
  } swpd_packet_t;

  typedef struct packed {
    logic last;     // the byte on hand completes a packet
    logic in_data;  // the byte on hand is a payload byte
  } swpd_status_t;

endpackage

@@ hdl/sync_word_packet_deframer_unit.sv @@
// Sync-word packet deframer: hunts a 4-byte header and emits 16-byte packets as four words.
// Each received byte is latched in an input register and handled from there by the
// framer, which checks it against the sync word or shifts it into the payload; the
// 16th payload byte loads the result register. One byte is taken every clock cycle while
// the input does not stall, and a result is offered in the cycle after the framer takes
// its last byte. The input stalls only when the last payload byte of a packet is on hand
// while the previous packet is still not taken. After a header mismatch the hunt resumes
// at the byte following the fourth header byte.
module sync_word_packet_deframer_unit
  import swpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sync_word_we_i,
  input  logic [31:0] sync_word_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        packet_valid_o,
  input  logic        packet_ready_i,
  output logic [31:0] frame_count_o,
  output logic [31:0] x_rate_bits_o,
  output logic [31:0] y_rate_bits_o,
  output logic [31:0] z_rate_bits_o
);

  logic [31:0]  sync_word_q;
  logic         byte_valid;
  logic [7:0]   byte_held;
  logic         out_free;
  logic         step;
  logic         load;
  swpd_status_t status;
  swpd_packet_t packet_next;
  swpd_packet_t packet_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SyncWordReset;
    end else if (sync_word_we_i) begin
      sync_word_q <= sync_word_wdata_i;
    end
  end

  assign step = byte_valid && (!status.last || out_free);
  assign load = step && status.last;

  swpd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .take_i       (step),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_held)
  );

  swpd_frame_fsm u_frame_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_held),
    .sync_word_i (sync_word_q),
    .status_o    (status),
    .packet_o    (packet_next)
  );

  swpd_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .packet_i       (packet_next),
    .free_o         (out_free),
    .packet_valid_o (packet_valid_o),
    .packet_ready_i (packet_ready_i),
    .packet_o       (packet_out)
  );

  assign frame_count_o = packet_out.frame_count;
  assign x_rate_bits_o = packet_out.x_rate_bits;
  assign y_rate_bits_o = packet_out.y_rate_bits;
  assign z_rate_bits_o = packet_out.z_rate_bits;

  // A result only appears after a last payload byte was processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(packet_valid_o) |-> $past(byte_valid && status.last && status.in_data))
    else $error("result raised without a completed packet");

  // A final byte held back by a full result register must stay in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid && status.last && packet_valid_o && !packet_ready_i) |=> byte_valid)
    else $error("last payload byte lost while result register was full");

  // A new packet never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!packet_valid_o || packet_ready_i))
    else $error("result register overwritten");

endmodule

@@ hdl/swpd_in_stage.sv @@
// Input register that holds one received byte until the framer takes it.
module swpd_in_stage
  import swpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign rx_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (rx_ready_o) begin
      valid_d = rx_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

@@ hdl/swpd_frame_fsm.sv @@
// Header hunt, header check and payload assembly, one byte per step.
module swpd_frame_fsm
  import swpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic [31:0]  sync_word_i,
  output swpd_status_t status_o,
  output swpd_packet_t packet_o
);

  logic [4:0]   pos_q, pos_d;
  logic         mismatch_q, mismatch_d;
  logic [127:0] payload_q;
  logic [127:0] payload_shifted;
  logic [7:0]   expected;
  logic         hunting;
  logic         in_header;
  logic         bad_so_far;

  // Positions beyond the last payload byte cannot occur but behave as hunting.
  assign hunting   = (pos_q == PosHunt) || (pos_q > PosLastData);
  assign in_header = !hunting && (pos_q <= PosLastHeader);

  always_comb begin
    case (pos_q[1:0])
      2'd1:    expected = sync_word_i[23:16];
      2'd2:    expected = sync_word_i[15:8];
      2'd3:    expected = sync_word_i[7:0];
      default: expected = sync_word_i[31:24];
    endcase
  end

  assign bad_so_far      = mismatch_q || (byte_i != expected);
  assign payload_shifted = {payload_q[119:0], byte_i};

  always_comb begin
    pos_d      = pos_q;
    mismatch_d = mismatch_q;
    if (hunting) begin
      if (byte_i == sync_word_i[31:24]) begin
        mismatch_d = 1'b0;
        pos_d      = 5'd1;
      end else begin
        pos_d = PosHunt;
      end
    end else if (in_header) begin
      mismatch_d = bad_so_far;
      if (pos_q == PosLastHeader) begin
        pos_d = bad_so_far ? PosHunt : PosFirstData;
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end else if (pos_q == PosLastData) begin
      pos_d = PosHunt;
    end else begin
      pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= PosHunt;
      mismatch_q <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      mismatch_q <= mismatch_d;
    end
  end

  // Payload bytes arrive in order, so one shift line yields all four words.
  always_ff @(posedge clk_i) begin
    if (step_i && !hunting && !in_header) begin
      payload_q <= payload_shifted;
    end
  end

  assign status_o.last    = (pos_q == PosLastData);
  assign status_o.in_data = !hunting && !in_header;
  assign packet_o         = swpd_packet_t'(payload_shifted);

endmodule

@@ hdl/swpd_out_stage.sv @@
// Result register that holds a finished packet until it is taken.
module swpd_out_stage
  import swpd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  swpd_packet_t packet_i,
  output logic         free_o,
  output logic         packet_valid_o,
  input  logic         packet_ready_i,
  output swpd_packet_t packet_o
);

  logic         valid_q, valid_d;
  swpd_packet_t packet_q;

  assign free_o = !valid_q || packet_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (packet_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      packet_q <= packet_i;
    end
  end

  assign packet_valid_o = valid_q;
  assign packet_o       = packet_q;

endmodule
